### hw/rtl/ascii_length_prefixed_deframer_unit_macros.svh
// Assertion macros for the deframer.
`ifndef ASCII_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH
`define ASCII_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ALPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ALPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

### hw/rtl/alpd_pkg.sv
package alpd_pkg;

	localparam int ByteW          = 8;
	localparam int ValW           = 14;
	localparam int FieldDigitsDef = 4;

	localparam logic [ValW-1:0]  ValMax    = 14'd16383;
	localparam logic [ByteW-1:0] AsciiZero = 8'h30;
	localparam logic [ByteW-1:0] AsciiNine = 8'h39;

	typedef logic [ValW-1:0] val_t;

	// Result of feeding one byte to an atoi-style accumulator.
	typedef struct packed {
		val_t acc;
		logic stopped;
	} digit_step_t;

	function automatic logic is_digit(input logic [ByteW-1:0] b);
		return (b >= AsciiZero) && (b <= AsciiNine);
	endfunction

	// acc*10 + digit, saturating; a non-digit stops the field.
	function automatic digit_step_t take_digit(input val_t acc, input logic stopped,
			input logic [ByteW-1:0] b);
		logic [ValW+4:0]  prod;
		logic [ByteW-1:0] dig;
		digit_step_t      r;
		r.acc     = acc;
		r.stopped = stopped;
		dig       = b - AsciiZero;
		prod      = {1'b0, acc, 4'b0} - {3'b0, acc, 2'b0} - {3'b0, acc, 2'b0}
			+ {5'b0, acc} + {5'b0, acc} + {{(ValW-3){1'b0}}, dig};
		if (!stopped) begin
			if (is_digit(b)) begin
				r.acc = (prod > {5'b0, ValMax}) ? ValMax : prod[ValW-1:0];
			end else begin
				r.stopped = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/ascii_length_prefixed_deframer_unit.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_byte
// output    out_valid / out_ready   body_byte, has_data, mode_byte, destination,
//                                   frame_length, frame_end
//
// One byte per cycle when not stalled: each accepted byte updates the parse
// state and, when it yields a result, loads the output register in the same cycle.
// in_ready is high whenever the output register is empty or being drained,
// so a held result only stalls input while out_ready is low.
// Output valid rises in the cycle after the input transfer.
// arst_n clears the parse state and the output valid; payload is not reset.
// Header bytes give no result, except the last header byte of a zero-length
// frame, which gives the empty end marker (has_data low, frame_end high).

`include "ascii_length_prefixed_deframer_unit_macros.svh"

module ascii_length_prefixed_deframer_unit #(
	parameter int FIELD_DIGITS = alpd_pkg::FieldDigitsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [alpd_pkg::ByteW-1:0] in_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [alpd_pkg::ByteW-1:0] body_byte,
	output logic                       has_data,
	output logic [alpd_pkg::ByteW-1:0] mode_byte,
	output alpd_pkg::val_t             destination,
	output alpd_pkg::val_t             frame_length,
	output logic                       frame_end
);

	localparam int HeaderBytes = 2 * FIELD_DIGITS + 1;
	localparam int PosW        = $clog2(HeaderBytes);

	// Parse state
	logic                       in_body_q;
	logic [PosW-1:0]            hdr_pos_q;
	alpd_pkg::val_t             len_q;
	logic                       len_stop_q;
	alpd_pkg::val_t             dest_q;
	logic                       dest_stop_q;
	logic [alpd_pkg::ByteW-1:0] mode_q;
	alpd_pkg::val_t             rem_q;

	// Next-state and result
	logic                       in_body_d;
	logic [PosW-1:0]            hdr_pos_d;
	alpd_pkg::val_t             len_d;
	logic                       len_stop_d;
	alpd_pkg::val_t             dest_d;
	logic                       dest_stop_d;
	logic [alpd_pkg::ByteW-1:0] mode_d;
	alpd_pkg::val_t             rem_d;
	logic                       emit;
	logic [alpd_pkg::ByteW-1:0] res_byte;
	logic                       res_data;
	logic                       res_end;

	// Header fields as seen by this byte: cleared at the start of a header
	alpd_pkg::val_t             len_cur;
	logic                       len_stop_cur;
	alpd_pkg::val_t             dest_cur;
	logic                       dest_stop_cur;
	logic [alpd_pkg::ByteW-1:0] mode_cur;
	alpd_pkg::digit_step_t      len_step;
	alpd_pkg::digit_step_t      dest_step;
	logic [PosW:0]              pos_inc;

	logic in_xfer;

	assign in_ready = !out_valid || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		len_cur       = len_q;
		len_stop_cur  = len_stop_q;
		dest_cur      = dest_q;
		dest_stop_cur = dest_stop_q;
		mode_cur      = mode_q;
		if (hdr_pos_q == '0) begin
			len_cur       = '0;
			len_stop_cur  = 1'b0;
			dest_cur      = '0;
			dest_stop_cur = 1'b0;
			mode_cur      = '0;
		end
		len_step  = alpd_pkg::take_digit(len_cur, len_stop_cur, in_byte);
		dest_step = alpd_pkg::take_digit(dest_cur, dest_stop_cur, in_byte);
		pos_inc   = {1'b0, hdr_pos_q} + (PosW+1)'(1);

		in_body_d   = in_body_q;
		hdr_pos_d   = hdr_pos_q;
		len_d       = len_q;
		len_stop_d  = len_stop_q;
		dest_d      = dest_q;
		dest_stop_d = dest_stop_q;
		mode_d      = mode_q;
		rem_d       = rem_q;
		emit        = 1'b0;
		res_byte    = in_byte;
		res_data    = 1'b1;
		res_end     = 1'b0;

		if (in_body_q) begin
			// body byte: count down, last one closes the frame
			rem_d   = (rem_q != '0) ? rem_q - alpd_pkg::val_t'(1) : '0;
			res_end = (rem_d == '0);
			emit    = 1'b1;
			if (res_end) begin
				in_body_d = 1'b0;
			end
		end else begin
			len_d       = len_cur;
			len_stop_d  = len_stop_cur;
			dest_d      = dest_cur;
			dest_stop_d = dest_stop_cur;
			mode_d      = mode_cur;
			if (hdr_pos_q < PosW'(FIELD_DIGITS)) begin
				len_d      = len_step.acc;
				len_stop_d = len_step.stopped;
			end else if (hdr_pos_q == PosW'(FIELD_DIGITS)) begin
				mode_d = in_byte;
			end else begin
				dest_d      = dest_step.acc;
				dest_stop_d = dest_step.stopped;
			end
			if (pos_inc == (PosW+1)'(HeaderBytes)) begin
				hdr_pos_d = '0;
				if (len_d == '0) begin
					// empty frame: one end marker
					emit     = 1'b1;
					res_byte = '0;
					res_data = 1'b0;
					res_end  = 1'b1;
				end else begin
					in_body_d = 1'b1;
					rem_d     = len_d;
				end
			end else begin
				hdr_pos_d = pos_inc[PosW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q   <= 1'b0;
			hdr_pos_q   <= '0;
			len_q       <= '0;
			len_stop_q  <= 1'b0;
			dest_q      <= '0;
			dest_stop_q <= 1'b0;
			mode_q      <= '0;
			rem_q       <= '0;
		end else if (in_xfer) begin
			in_body_q   <= in_body_d;
			hdr_pos_q   <= hdr_pos_d;
			len_q       <= len_d;
			len_stop_q  <= len_stop_d;
			dest_q      <= dest_d;
			dest_stop_q <= dest_stop_d;
			mode_q      <= mode_d;
			rem_q       <= rem_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_xfer && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			body_byte    <= res_byte;
			has_data     <= res_data;
			mode_byte    <= mode_d;
			destination  <= dest_d;
			frame_length <= len_d;
			frame_end    <= res_end;
		end
	end

	// Checks
	`ALPD_ASSERT_NOW(a_marker_empty, out_valid && !has_data,
		frame_end && frame_length == '0 && body_byte == '0)
	`ALPD_ASSERT_NOW(a_data_has_len, out_valid && has_data, frame_length != '0)
	`ALPD_ASSERT_NOW(a_body_no_hdr, in_body_q, hdr_pos_q == '0 && rem_q != '0)
	`ALPD_ASSERT_NEXT(a_last_body, in_xfer && in_body_q && rem_q == alpd_pkg::val_t'(1),
		!in_body_q && out_valid && frame_end)

endmodule

### test/ascii_length_prefixed_deframer_unit_tb.sv
`timescale 1ns / 1ps

typedef logic [alpd_pkg::ByteW-1:0] octet_t;

// One body byte or empty end marker, as it leaves the deframer.
typedef struct packed {
	octet_t         body;
	logic           has_data;
	octet_t         mode;
	alpd_pkg::val_t dest;
	alpd_pkg::val_t len;
	logic           last;
} deframe_rec_t;

class deframe_scoreboard;
	localparam int Digits   = alpd_pkg::FieldDigitsDef;
	localparam int HdrBytes = 2 * Digits + 1;

	bit             in_body;
	int unsigned    hdr_pos;
	alpd_pkg::val_t len_acc;
	alpd_pkg::val_t dest_acc;
	alpd_pkg::val_t body_left;
	bit             len_stop;
	bit             dest_stop;
	octet_t         mode_hold;
	deframe_rec_t   expected_results[$];
	int unsigned    errors;

	function new();
		in_body   = 1'b0;
		hdr_pos   = 0;
		len_acc   = '0;
		dest_acc  = '0;
		body_left = '0;
		len_stop  = 1'b0;
		dest_stop = 1'b0;
		mode_hold = '0;
		errors    = 0;
	endfunction

	// atoi-style digit accumulation, saturating
	static function void accumulate(inout alpd_pkg::val_t acc, inout bit stop,
			input octet_t b);
		int unsigned v;
		if (stop)
			return;
		if (b >= alpd_pkg::AsciiZero && b <= alpd_pkg::AsciiNine) begin
			v   = int'(acc) * 10 + int'(b - alpd_pkg::AsciiZero);
			acc = (v > int'(alpd_pkg::ValMax)) ? alpd_pkg::ValMax : alpd_pkg::val_t'(v);
		end else begin
			stop = 1'b1;
		end
	endfunction

	function void take_byte(octet_t b);
		if (in_body) begin
			body_left = (body_left > 0) ? body_left - 1'b1 : '0;
			expected_results.push_back('{b, 1'b1, mode_hold, dest_acc, len_acc,
				body_left == 0});
			if (body_left == 0)
				in_body = 1'b0;
			return;
		end
		if (hdr_pos == 0) begin
			len_acc   = '0;
			len_stop  = 1'b0;
			dest_acc  = '0;
			dest_stop = 1'b0;
			mode_hold = '0;
		end
		if (hdr_pos < Digits)
			accumulate(len_acc, len_stop, b);
		else if (hdr_pos == Digits)
			mode_hold = b;
		else
			accumulate(dest_acc, dest_stop, b);
		hdr_pos++;
		if (hdr_pos < HdrBytes)
			return;
		hdr_pos = 0;
		if (len_acc == 0) begin
			expected_results.push_back('{8'h00, 1'b0, mode_hold, dest_acc, len_acc, 1'b1});
		end else begin
			in_body   = 1'b1;
			body_left = len_acc;
		end
	endfunction

	function int unsigned pending();
		return expected_results.size();
	endfunction

	task report(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(deframe_rec_t got);
		deframe_rec_t want;
		if (expected_results.size() == 0) begin
			report($sformatf("unexpected result body=%0h end=%0b", got.body, got.last));
			return;
		end
		want = expected_results.pop_front();
		if (got.body !== want.body)
			report($sformatf("body_byte %0h, want %0h", got.body, want.body));
		if (got.has_data !== want.has_data)
			report($sformatf("has_data %0b, want %0b", got.has_data, want.has_data));
		if (got.mode !== want.mode)
			report($sformatf("mode_byte %0h, want %0h", got.mode, want.mode));
		if (got.dest !== want.dest)
			report($sformatf("destination %0d, want %0d", got.dest, want.dest));
		if (got.len !== want.len)
			report($sformatf("frame_length %0d, want %0d", got.len, want.len));
		if (got.last !== want.last)
			report($sformatf("frame_end %0b, want %0b", got.last, want.last));
	endtask

	task flush();
		while (expected_results.size() != 0) begin
			report("result never arrived");
			void'(expected_results.pop_front());
		end
	endtask
endclass

module ascii_length_prefixed_deframer_unit_tb;

	localparam int Digits      = alpd_pkg::FieldDigitsDef;
	localparam int RandItems   = 1600;
	localparam int LongHold    = 300;	// receiver hold-off, long enough to back up the input
	localparam int CycleLimit  = 1000000;
	localparam int DrainEvery  = 500;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	octet_t         in_byte = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	octet_t         body_byte;
	logic           has_data;
	octet_t         mode_byte;
	alpd_pkg::val_t destination;
	alpd_pkg::val_t frame_length;
	logic           frame_end;

	deframe_scoreboard sb = new();

	octet_t      hdr_q[$];	// header bytes of the next frame
	octet_t      body_q[$];	// fixed leading body bytes, random ones follow
	bit          offering = 1'b0;	// mirrors what in_valid has been driven to
	int unsigned burst_left = 0;
	int unsigned n_sent = 0;
	bit          hold_req = 1'b0;
	int unsigned cycles = 0;

	ascii_length_prefixed_deframer_unit u_top (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog: anything still running here has hung.
	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Receiver: checks every output transfer and drives out_ready from a
	// pattern that changes every so often. A hold request from the stimulus
	// side forces a long stall, counted down here.
	// ---------------------------------------------------------------------
	initial begin : rx
		int unsigned pat;
		int unsigned pat_left;
		int unsigned hold_left;
		pat       = 0;
		pat_left  = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			// pre-edge values: the block updates by NBA, so no race here
			if (out_valid && out_ready)
				sb.check_result('{body_byte, has_data, mode_byte, destination,
					frame_length, frame_end});
			if (hold_req) begin
				hold_left = LongHold;
				hold_req  = 1'b0;
			end
			if (pat_left == 0) begin
				pat      = $urandom_range(3);
				pat_left = $urandom_range(10, 120);
			end
			pat_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (pat)
					0: out_ready <= 1'b1;	// stretch with no stalls
					1: out_ready <= ($urandom_range(3) != 0);
					2: out_ready <= ~out_ready;
					default: out_ready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------
	function automatic int unsigned next_burst();
		// now and then a long burst so the input runs back-to-back
		return ($urandom_range(4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
	endfunction

	task automatic lower_valid();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// One input transfer, noted in the scoreboard on acceptance; the burst
	// logic decides whether valid drops afterwards.
	task automatic send_byte(input octet_t b);
		in_byte  <= b;
		in_valid <= 1'b1;
		offering = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_byte(b);
		n_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			lower_valid();
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = next_burst();
		end
	endtask

	// Sender pauses until every expected result has been taken.
	task automatic wait_drained();
		lower_valid();
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Header as built, then the fixed body bytes, then random body bytes for
	// as long as the decoded length asks. Keeps the stream aligned to frames.
	task automatic send_frame();
		foreach (hdr_q[i])
			send_byte(hdr_q[i]);
		foreach (body_q[i])
			send_byte(body_q[i]);
		while (sb.in_body)
			send_byte(octet_t'($urandom_range(255)));
		hdr_q.delete();
		body_q.delete();
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			hdr_q.push_back(octet_t'(s[i]));
	endfunction

	function automatic octet_t pick_nondigit();
		octet_t b;
		case ($urandom_range(3))
			0: b = "+";
			1: b = "-";
			2: b = " ";
			default: begin
				do
					b = octet_t'($urandom_range(255));
				while (b >= alpd_pkg::AsciiZero && b <= alpd_pkg::AsciiNine);
			end
		endcase
		return b;
	endfunction

	// Decimal field of Digits bytes.
	// style 0: zero-padded digits; 1: digits cut short by a non-digit;
	// 2: non-digit first; otherwise raw random bytes.
	function automatic void add_field(input int unsigned v, input int unsigned style);
		int unsigned pw;
		int unsigned cut;
		pw = 1;
		for (int i = 1; i < Digits; i++)
			pw *= 10;
		cut = (style == 1) ? $urandom_range(1, Digits - 1) : (style == 2) ? 0 : Digits;
		for (int i = 0; i < Digits; i++) begin
			if (style > 2 || i > cut)
				hdr_q.push_back(octet_t'($urandom_range(255)));
			else if (i == cut)
				hdr_q.push_back(pick_nondigit());
			else
				hdr_q.push_back(alpd_pkg::AsciiZero + octet_t'((v / pw) % 10));
			pw /= 10;
		end
	endfunction

	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(0, 6);
		if (r < 90)
			return $urandom_range(7, 40);
		return $urandom_range(41, 150);
	endfunction

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : stim
		int unsigned start;
		int unsigned next_drain;
		bit          hold_done;
		bit          clean;

		hold_done  = 1'b0;
		burst_left = next_burst();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Zero length behind a leading space, top destination: one empty end marker.
		add_text(" 001");
		hdr_q.push_back(8'h4D);
		add_text("9999");
		send_frame();

		// Length cut short by a minus, sign-first destination, extreme bytes.
		add_text("2-99");
		hdr_q.push_back(8'hFF);
		add_text("+123");
		body_q.push_back(8'h00);
		body_q.push_back(8'hFF);
		send_frame();
		wait_drained();

		// A long frame, several hundred body bytes.
		add_field($urandom_range(300, 500), 0);
		hdr_q.push_back(octet_t'($urandom_range(255)));
		add_field($urandom_range(0, 9999), 0);
		send_frame();
		wait_drained();

		// Random frames: mostly well formed, some mangled headers.
		start      = n_sent;
		next_drain = n_sent + DrainEvery;
		while (n_sent - start < RandItems) begin
			if (!hold_done && n_sent - start > 600) begin
				hold_req  = 1'b1;	// sender keeps going while the receiver holds off
				hold_done = 1'b1;
			end
			if (n_sent >= next_drain) begin
				wait_drained();
				next_drain = n_sent + DrainEvery;
			end
			if ($urandom_range(4) != 0) begin
				add_field(pick_length(), ($urandom_range(9) == 0) ? 1 : 0);
				hdr_q.push_back(octet_t'($urandom_range(255)));
				add_field($urandom_range(0, 9999), $urandom_range(0, 4) == 0 ? 1 : 0);
			end else begin
				add_field(pick_length(), $urandom_range(1, 3));
				hdr_q.push_back(octet_t'($urandom_range(255)));
				add_field($urandom_range(0, 9999), $urandom_range(1, 3));
			end
			send_frame();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		sb.flush();
		clean = (sb.errors == 0);
		if (clean)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
